[rtl/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg: RGB to HSL converter shared definitions
// Widths, per-lane divider state and the output fitting helper.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int CHAN_W        = 8;
  localparam int COLOR_W       = 3 * CHAN_W;
  localparam int OUT_W         = 16;

  // quotient bits per division, one divider cell per bit
  localparam int QUO_W = FRACTION_BITS + 1;
  // divisor width: largest divisor is 12 * 255
  localparam int DIV_W = 12;
  // rounding numerator width: largest is (6*255 << (FRACTION_BITS+1)) + 6*255
  localparam int NUM_W = FRACTION_BITS + 12;

  typedef struct packed {
    logic [DIV_W-1:0] rem;  // partial remainder
    logic [QUO_W-1:0] nq;   // numerator bits still to shift in, quotient bits shifted out
    logic [DIV_W-1:0] div;  // divisor
  } lane_t;

  typedef struct packed {
    lane_t hue;
    lane_t sat;
    lane_t light;
  } cell_data_t;

  function automatic logic [OUT_W-1:0] fit_out(input logic [QUO_W-1:0] q);
    logic [OUT_W+QUO_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, q};
    return ext[OUT_W-1:0];
  endfunction

endpackage

[rtl/rhc_if.sv]
// ----------------------------------------------------------------------------
// rhc_if: stream channels of the RGB to HSL converter
// Pixel channel and HSL result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rhc_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [rhc_pkg::COLOR_W-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

interface rhc_hsl_if;
  logic                     valid;
  logic                     ready;
  logic [rhc_pkg::OUT_W-1:0] hue;
  logic [rhc_pkg::OUT_W-1:0] saturation;
  logic [rhc_pkg::OUT_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

[rtl/rhc_front.sv]
// ----------------------------------------------------------------------------
// rhc_front: pixel front end
// Two stages: max/min and hue sector, then rounding numerators and divisors
// for the hue, saturation and lightness divider lanes.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic                clk,
  input  logic                rst,
  rhc_pixel_if.sink           pixel,
  output logic                out_valid,
  input  logic                out_ready,
  output rhc_pkg::cell_data_t out_data
);
  import rhc_pkg::*;

  localparam int SUM_W   = CHAN_W + 1;
  localparam int HNUM_W  = CHAN_W + 3;
  localparam int ChanMax = (1 << CHAN_W) - 1;
  localparam int TwoMax  = 2 * ChanMax;
  localparam int LightDiv = 2 * TwoMax;

  typedef enum logic [2:0] {
    SECT_RED   = 3'b001,
    SECT_GREEN = 3'b010,
    SECT_BLUE  = 3'b100
  } sector_t;

  function automatic lane_t make_lane(input logic [NUM_W-1:0] n,
                                      input logic [DIV_W-1:0] d);
    lane_t l;
    l.rem = DIV_W'(n[NUM_W-1:QUO_W]);
    l.nq  = n[QUO_W-1:0];
    l.div = d;
    return l;
  endfunction

  // ---------------- stage A ----------------
  logic [CHAN_W-1:0] r, g, b, mx_rg, mn_rg, mx, mn;
  logic [CHAN_W-1:0] plus_c, minus_c;
  sector_t           sector_c;

  logic              a_valid, a_ready;
  logic [SUM_W-1:0]  a_sum;
  logic [CHAN_W-1:0] a_spread, a_plus, a_minus;
  sector_t           a_sector;

  logic              b_ready;

  always_comb begin
    r     = pixel.color[CHAN_W-1:0];
    g     = pixel.color[2*CHAN_W-1:CHAN_W];
    b     = pixel.color[3*CHAN_W-1:2*CHAN_W];
    mx_rg = (g > r) ? g : r;
    mn_rg = (g < r) ? g : r;
    mx    = (b > mx_rg) ? b : mx_rg;
    mn    = (b < mn_rg) ? b : mn_rg;
    if (r == mx) begin
      sector_c = SECT_RED;
      plus_c   = g;
      minus_c  = b;
    end else if (g == mx) begin
      sector_c = SECT_GREEN;
      plus_c   = b;
      minus_c  = r;
    end else begin
      sector_c = SECT_BLUE;
      plus_c   = r;
      minus_c  = g;
    end
  end

  assign a_ready     = !a_valid || b_ready;
  assign pixel.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && pixel.valid) begin
      a_sum    <= SUM_W'(mx) + SUM_W'(mn);
      a_spread <= mx - mn;
      a_sector <= sector_c;
      a_plus   <= plus_c;
      a_minus  <= minus_c;
    end
  end

  // ---------------- stage B ----------------
  logic [HNUM_W-1:0] six, base, hsum, num;
  logic [SUM_W-1:0]  den;
  logic [NUM_W-1:0]  hue_n, sat_n, light_n, sat_full, light_full;
  logic [DIV_W-1:0]  hue_d, sat_d;
  logic              gray;
  cell_data_t        lanes;

  always_comb begin
    six = (HNUM_W'(a_spread) << 2) + (HNUM_W'(a_spread) << 1);
    unique case (a_sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HNUM_W'(a_spread) << 1;
      SECT_BLUE:  base = HNUM_W'(a_spread) << 2;
      default:    base = '0;
    endcase
    hsum = base + HNUM_W'(a_plus);
    // negative angle wraps by one turn
    if (hsum < HNUM_W'(a_minus)) begin
      num = hsum + six - HNUM_W'(a_minus);
    end else begin
      num = hsum - HNUM_W'(a_minus);
    end
    gray = (a_spread == '0);

    hue_n = (NUM_W'(num) << (FRACTION_BITS + 1)) + NUM_W'(six);
    hue_d = DIV_W'({six, 1'b0});

    den = (a_sum < SUM_W'(ChanMax)) ? a_sum : SUM_W'(TwoMax) - a_sum;
    sat_full = (NUM_W'(a_spread) << FRACTION_BITS) - NUM_W'(a_spread);
    sat_n    = (sat_full << 1) + NUM_W'(den);
    sat_d    = DIV_W'({den, 1'b0});

    light_full = (NUM_W'(a_sum) << FRACTION_BITS) - NUM_W'(a_sum);
    light_n    = (light_full << 1) + NUM_W'(TwoMax);

    if (gray) begin
      hue_n = '0;
      hue_d = DIV_W'(1);
      sat_n = '0;
      sat_d = DIV_W'(1);
    end

    lanes.hue   = make_lane(hue_n, hue_d);
    lanes.sat   = make_lane(sat_n, sat_d);
    lanes.light = make_lane(light_n, DIV_W'(LightDiv));
  end

  assign b_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      out_data <= lanes;
    end
  end

endmodule

[rtl/rhc_cell.sv]
// ----------------------------------------------------------------------------
// rhc_cell: one restoring divider step
// Shifts one numerator bit into each lane's remainder, produces one
// quotient bit per lane and hands the result to the next cell.
// ----------------------------------------------------------------------------
module rhc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhc_pkg::cell_data_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rhc_pkg::cell_data_t out_data
);
  import rhc_pkg::*;

  function automatic lane_t div_step(input lane_t l);
    logic [DIV_W:0] t;
    logic           ge;
    lane_t          s;
    t     = {l.rem, l.nq[QUO_W-1]};
    ge    = (t >= {1'b0, l.div});
    s.div = l.div;
    s.nq  = {l.nq[QUO_W-2:0], ge};
    s.rem = ge ? DIV_W'(t - {1'b0, l.div}) : DIV_W'(t);
    return s;
  endfunction

  cell_data_t step_data;

  always_comb begin
    step_data.hue   = div_step(in_data.hue);
    step_data.sat   = div_step(in_data.sat);
    step_data.light = div_step(in_data.light);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step_data;
    end
  end

endmodule

[rtl/rgb_to_hsl_converter_unit.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit: RGB to HSL converter
// Pipeline: 2 front-end stages plus one cell per quotient bit (17 cells).
// Throughput: one pixel per cycle while hsl.ready is not held low; every
// stage holds one pixel in flight.
// Reset clears the valid flags only; data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_unit (
  input  logic       clk,
  input  logic       rst,
  rhc_pixel_if.sink  pixel,
  rhc_hsl_if.source  hsl
);
  import rhc_pkg::*;

  logic       valid [QUO_W+1];
  logic       ready [QUO_W+1];
  cell_data_t data  [QUO_W+1];

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_data  (data[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_data  (data[i+1])
    );
  end

  // last cell register is the output register
  assign hsl.valid      = valid[QUO_W];
  assign ready[QUO_W]   = hsl.ready;
  // hue rounding up to a full turn wraps to zero
  assign hsl.hue        = fit_out({1'b0, data[QUO_W].hue.nq[FRACTION_BITS-1:0]});
  assign hsl.saturation = fit_out(data[QUO_W].sat.nq);
  assign hsl.lightness  = fit_out(data[QUO_W].light.nq);

endmodule
